// ===== rtl/nia_pkg.sv =====
// Shared types, codes and constants for the navigation input autorepeat block.
// No dependencies; imported by every module under rtl/.
package nia_pkg;

    // Fixed field widths
    localparam int DT_W       = 18;
    localparam int DELAY_W    = 19;
    localparam int LEVEL_W    = 15;
    localparam int PTR_W      = 16;
    localparam int BTN_DIR_W  = 3;
    localparam int BTN_ACT_W  = 2;
    localparam int ACTIONS    = 6;
    localparam int DIRS       = 4;
    localparam int CFG_IDX_W  = 2;
    // Signed compare width for stick amount against a level (axis up to 16 bits)
    localparam int CMP_W      = 17;

    // Parameter defaults
    localparam int TIMER_BITS_DEF = 20;
    localparam int AXIS_BITS_DEF  = 16;

    // Register reset values
    localparam logic [DELAY_W-1:0] RESET_DELAY    = 19'd400000;
    localparam logic [DELAY_W-1:0] RESET_INTERVAL = 19'd100000;
    localparam logic [LEVEL_W-1:0] RESET_TRIGGER  = 15'd16384;
    localparam logic [LEVEL_W-1:0] RESET_RELEASE  = 15'd8192;

    // Action bit positions
    localparam int ACT_UP      = 0;
    localparam int ACT_DOWN    = 1;
    localparam int ACT_LEFT    = 2;
    localparam int ACT_RIGHT   = 3;
    localparam int ACT_CONFIRM = 4;
    localparam int ACT_CANCEL  = 5;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_RESET = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_WAIT      = 2'd0,
        CFG_REPEAT_PERIOD   = 2'd1,
        CFG_TRIGGER_LEVEL   = 2'd2,
        CFG_RELEASE_LEVEL   = 2'd3
    } cfg_idx_t;

    // Per-item control from the top level to the state holders
    typedef struct packed {
        logic step;   // a tick is being processed this cycle
        logic clear;  // a reset command is being processed this cycle
    } step_ctl_t;

endpackage

// ===== rtl/nia_stick.sv =====
// Stick to four digital directions with hysteresis; holds the latched bits.
// Depends on nia_pkg.
module nia_stick
    import nia_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  step_ctl_t                   ctl,
    input  logic signed [AXIS_BITS-1:0] axis_x,
    input  logic signed [AXIS_BITS-1:0] axis_y,
    input  logic [LEVEL_W-1:0]          trigger_level,
    input  logic [LEVEL_W-1:0]          release_level,
    output logic [DIRS-1:0]             active
);

    localparam logic [AXIS_BITS-1:0] AMIN = {1'b1, {(AXIS_BITS-1){1'b0}}};
    localparam logic [AXIS_BITS-1:0] AMAX = {1'b0, {(AXIS_BITS-1){1'b1}}};

    logic [DIRS-1:0]         latched_reg;
    logic [DIRS-1:0]         latched_next;
    logic [AXIS_BITS-1:0]    neg_x;
    logic [AXIS_BITS-1:0]    neg_y;
    logic signed [CMP_W-1:0] amount [DIRS];
    logic signed [CMP_W-1:0] trig_s;
    logic signed [CMP_W-1:0] rel_s;

    // Saturating negation: the most negative value maps to the most positive
    assign neg_x = (axis_x == AMIN) ? AMAX : -axis_x;
    assign neg_y = (axis_y == AMIN) ? AMAX : -axis_y;

    assign amount[ACT_UP]    = {{(CMP_W-AXIS_BITS){axis_y[AXIS_BITS-1]}}, axis_y};
    assign amount[ACT_DOWN]  = {{(CMP_W-AXIS_BITS){neg_y[AXIS_BITS-1]}}, neg_y};
    assign amount[ACT_LEFT]  = {{(CMP_W-AXIS_BITS){neg_x[AXIS_BITS-1]}}, neg_x};
    assign amount[ACT_RIGHT] = {{(CMP_W-AXIS_BITS){axis_x[AXIS_BITS-1]}}, axis_x};

    assign trig_s = $signed({{(CMP_W-LEVEL_W){1'b0}}, trigger_level});
    assign rel_s  = $signed({{(CMP_W-LEVEL_W){1'b0}}, release_level});

    // Hysteresis: an active direction uses the release level
    always_comb
    begin
        for (int d = 0; d < DIRS; d++)
        begin
            active[d] = latched_reg[d] ? (amount[d] >= rel_s) : (amount[d] >= trig_s);
        end
    end

    always_comb
    begin
        latched_next = latched_reg;
        if (ctl.clear)
        begin
            latched_next = '0;
        end
        else if (ctl.step)
        begin
            latched_next = active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= '0;
        end
        else
        begin
            latched_reg <= latched_next;
        end
    end

endmodule

// ===== rtl/nia_action.sv =====
// One action: press edge detect and typematic repeat countdown.
// Depends on nia_pkg.
module nia_action
    import nia_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter bit REPEAT     = 1'b1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  step_ctl_t          ctl,
    input  logic               down,
    input  logic [DT_W-1:0]    dt,
    input  logic [DELAY_W-1:0] first_wait,
    input  logic [DELAY_W-1:0] repeat_period,
    output logic               fired
);

    // Widths wide enough for both operands of each compare
    localparam int LW = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;
    localparam int CW = (TIMER_BITS > DT_W) ? TIMER_BITS : DT_W;
    localparam logic [LW-1:0] TMAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

    logic                  held_reg;
    logic                  held_next;
    logic [TIMER_BITS-1:0] count_reg;
    logic [TIMER_BITS-1:0] count_next;
    logic [TIMER_BITS-1:0] delay_load;
    logic [TIMER_BITS-1:0] interval_load;
    logic [CW-1:0]         dt_ext;
    logic [CW-1:0]         count_ext;
    logic                  expired;

    function automatic logic [TIMER_BITS-1:0] clamp_load(input logic [DELAY_W-1:0] v);
        logic [LW-1:0] v_ext;
        v_ext = LW'(v);
        return (v_ext > TMAX) ? TMAX[TIMER_BITS-1:0] : v_ext[TIMER_BITS-1:0];
    endfunction

    assign delay_load    = clamp_load(first_wait);
    assign interval_load = clamp_load(repeat_period);
    assign dt_ext        = CW'(dt);
    assign count_ext     = CW'(count_reg);
    assign expired       = (dt_ext >= count_ext);

    // Next state and fire decision for one tick
    always_comb
    begin
        held_next  = held_reg;
        count_next = count_reg;
        fired      = 1'b0;
        if (ctl.clear)
        begin
            held_next  = 1'b1;
            count_next = '0;
        end
        else if (ctl.step)
        begin
            if (!down)
            begin
                held_next  = 1'b0;
                count_next = '0;
            end
            else if (!held_reg)
            begin
                held_next  = 1'b1;
                fired      = 1'b1;
                count_next = delay_load;
            end
            else if (REPEAT)
            begin
                if (expired)
                begin
                    fired      = 1'b1;
                    count_next = interval_load;
                end
                else
                begin
                    count_next = TIMER_BITS'(count_ext - dt_ext);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b1;
            count_reg <= '0;
        end
        else
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/nav_input_autorepeat_core.sv =====
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in      | in  | in_valid / in_ready  | command, elapsed_us, axis_*, *_buttons, pointer_*
//  out     | out | out_valid / out_ready| fired_actions, focus_shown, stick_active
//  cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while out_ready is held high. An accepted item waits in the
// input register until the output register is free or being drained; it is then processed
// out of the input register and its result is loaded into the output register, which sets
// out_valid. The output register stalls on out_ready; the input register keeps accepting
// while the output register is free or being drained.
// rst_n clears all mapper state to the reset-command state and the registers to defaults.
// Depends on nia_pkg, nia_stick, nia_action.
module nav_input_autorepeat_core
    import nia_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int AXIS_BITS  = AXIS_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DELAY_W-1:0]          cfg_data,
    // input items
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [DT_W-1:0]             elapsed_us,
    input  logic signed [AXIS_BITS-1:0] axis_x,
    input  logic signed [AXIS_BITS-1:0] axis_y,
    input  logic [BTN_DIR_W-1:0]        up_buttons,
    input  logic [BTN_DIR_W-1:0]        down_buttons,
    input  logic [BTN_DIR_W-1:0]        left_buttons,
    input  logic [BTN_DIR_W-1:0]        right_buttons,
    input  logic [BTN_ACT_W-1:0]        confirm_buttons,
    input  logic [BTN_ACT_W-1:0]        cancel_buttons,
    input  logic [PTR_W-1:0]            pointer_x,
    input  logic [PTR_W-1:0]            pointer_y,
    // result items
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ACTIONS-1:0]          fired_actions,
    output logic                        focus_shown,
    output logic [DIRS-1:0]             stick_active
);

    // Configuration registers
    logic [DELAY_W-1:0] delay_reg;
    logic [DELAY_W-1:0] interval_reg;
    logic [LEVEL_W-1:0] trigger_reg;
    logic [LEVEL_W-1:0] release_reg;

    // Input register
    logic                        in_valid_reg;
    logic                        command_reg;
    logic [DT_W-1:0]             dt_reg;
    logic signed [AXIS_BITS-1:0] axis_x_reg;
    logic signed [AXIS_BITS-1:0] axis_y_reg;
    logic [BTN_DIR_W-1:0]        dir_btn_reg [DIRS];
    logic [BTN_ACT_W-1:0]        confirm_reg;
    logic [BTN_ACT_W-1:0]        cancel_reg;
    logic [PTR_W-1:0]            px_reg;
    logic [PTR_W-1:0]            py_reg;

    // Mapper state kept here
    logic               focus_reg;
    logic               focus_next;
    logic               seen_reg;
    logic [PTR_W-1:0]   last_px_reg;
    logic [PTR_W-1:0]   last_py_reg;

    // Output register
    logic               out_valid_reg;
    logic [ACTIONS-1:0] fired_reg;
    logic               shown_reg;
    logic [DIRS-1:0]    stick_reg;

    logic               advance;
    logic               in_take;
    step_ctl_t          ctl;
    logic [DIRS-1:0]    stick_now;
    logic [ACTIONS-1:0] down_now;
    logic [ACTIONS-1:0] fired_now;
    logic               moved;

    // Handshakes
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign ctl.step  = advance && (command_reg == CMD_TICK);
    assign ctl.clear = advance && (command_reg == CMD_RESET);

    assign out_valid     = out_valid_reg;
    assign fired_actions = fired_reg;
    assign focus_shown   = shown_reg;
    assign stick_active  = stick_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= RESET_DELAY;
            interval_reg <= RESET_INTERVAL;
            trigger_reg  <= RESET_TRIGGER;
            release_reg  <= RESET_RELEASE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIRST_WAIT:      delay_reg    <= cfg_data;
                CFG_REPEAT_PERIOD:   interval_reg <= cfg_data;
                CFG_TRIGGER_LEVEL:   trigger_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_RELEASE_LEVEL:   release_reg  <= cfg_data[LEVEL_W-1:0];
                default:             ;
            endcase
        end
    end

    // Input register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            command_reg          <= command;
            dt_reg               <= elapsed_us;
            axis_x_reg           <= axis_x;
            axis_y_reg           <= axis_y;
            dir_btn_reg[ACT_UP]    <= up_buttons;
            dir_btn_reg[ACT_DOWN]  <= down_buttons;
            dir_btn_reg[ACT_LEFT]  <= left_buttons;
            dir_btn_reg[ACT_RIGHT] <= right_buttons;
            confirm_reg          <= confirm_buttons;
            cancel_reg           <= cancel_buttons;
            px_reg               <= pointer_x;
            py_reg               <= pointer_y;
        end
    end

    nia_stick #(
        .AXIS_BITS     (AXIS_BITS)
    ) u_stick (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .axis_x        (axis_x_reg),
        .axis_y        (axis_y_reg),
        .trigger_level (trigger_reg),
        .release_level (release_reg),
        .active        (stick_now)
    );

    // Direction actions: any key, button or stick direction
    always_comb
    begin
        for (int d = 0; d < DIRS; d++)
        begin
            down_now[d] = (|dir_btn_reg[d]) || stick_now[d];
        end
        down_now[ACT_CONFIRM] = |confirm_reg;
        down_now[ACT_CANCEL]  = |cancel_reg;
    end

    for (genvar a = 0; a < ACTIONS; a++)
    begin : g_action
        nia_action #(
            .TIMER_BITS      (TIMER_BITS),
            .REPEAT          (a < DIRS)
        ) u_action (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctl             (ctl),
            .down            (down_now[a]),
            .dt              (dt_reg),
            .first_wait      (delay_reg),
            .repeat_period   (interval_reg),
            .fired           (fired_now[a])
        );
    end

    // Focus mark: set by any fire, cleared by pointer movement
    assign moved = seen_reg && ((px_reg != last_px_reg) || (py_reg != last_py_reg));

    always_comb
    begin
        focus_next = focus_reg;
        if (|fired_now)
        begin
            focus_next = 1'b1;
        end
        if (moved)
        begin
            focus_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_reg   <= 1'b0;
            seen_reg    <= 1'b0;
            last_px_reg <= '0;
            last_py_reg <= '0;
        end
        else if (ctl.clear)
        begin
            focus_reg   <= 1'b0;
            seen_reg    <= 1'b0;
            last_px_reg <= '0;
            last_py_reg <= '0;
        end
        else if (ctl.step)
        begin
            focus_reg   <= focus_next;
            seen_reg    <= 1'b1;
            last_px_reg <= px_reg;
            last_py_reg <= py_reg;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload, zero after a reset command
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (ctl.clear)
            begin
                fired_reg <= '0;
                shown_reg <= 1'b0;
                stick_reg <= '0;
            end
            else
            begin
                fired_reg <= fired_now;
                shown_reg <= focus_next;
                stick_reg <= stick_now;
            end
        end
    end

endmodule

// ===== rtl/nia_checker.sv =====
// Port-level checks for nav_input_autorepeat_core, bound to every instance.
// Depends on nia_pkg and the top level's port list.
module nia_checker
    import nia_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_ready,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ACTIONS-1:0] fired_actions
);

    // Items accepted but not yet delivered
    logic [1:0] occ_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= 2'(occ_reg + {1'b0, in_acc} - {1'b0, out_acc});
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired_actions))
        else $error("result item changed while stalled");

    // No more than two items in flight
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("more than two items in flight");

    // A result is only shown for an accepted item
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != 2'd0)
        else $error("result item without an accepted input item");

    // Input only stalls when both registers are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> occ_reg == 2'd2 && out_valid && !out_ready)
        else $error("input stalled while there is room");

    // Configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind nav_input_autorepeat_core nia_checker u_nia_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg_ready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fired_actions (fired_actions)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nav_input_autorepeat_core: a queue-fed driver, a stalling
// monitor and an in-bench predictor of the tick / reset-command mapper with autorepeat.
// Depends on nia_pkg and the RTL under rtl/.
module testbench;
    import nia_pkg::*;

    localparam int AXIS_W  = AXIS_BITS_DEF;
    localparam int TIMER_W = TIMER_BITS_DEF;
    localparam int AXIS_TOP = 2 ** (AXIS_W - 1) - 1;
    localparam int DT_MAX   = 2 ** DT_W - 1;

    typedef struct packed {
        cmd_t                     command;
        logic [DT_W-1:0]          elapsed_us;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic [BTN_DIR_W-1:0]     up_buttons;
        logic [BTN_DIR_W-1:0]     down_buttons;
        logic [BTN_DIR_W-1:0]     left_buttons;
        logic [BTN_DIR_W-1:0]     right_buttons;
        logic [BTN_ACT_W-1:0]     confirm_buttons;
        logic [BTN_ACT_W-1:0]     cancel_buttons;
        logic [PTR_W-1:0]         pointer_x;
        logic [PTR_W-1:0]         pointer_y;
    } nav_item_t;

    typedef struct packed {
        logic [ACTIONS-1:0] fired;
        logic               focus;
        logic [DIRS-1:0]    stick;
    } nav_result_t;

    typedef struct packed {
        cfg_idx_t           idx;
        logic [DELAY_W-1:0] data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    reg_write_t         cur_write = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    nav_item_t          cur_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ACTIONS-1:0] fired_actions;
    logic               focus_shown;
    logic [DIRS-1:0]    stick_active;

    nav_item_t   pending_items [$];
    reg_write_t  pending_writes [$];
    nav_result_t expected_results [$];

    // Register copies
    logic [DELAY_W-1:0] cf_delay;
    logic [DELAY_W-1:0] cf_interval;
    logic [LEVEL_W-1:0] cf_trigger;
    logic [LEVEL_W-1:0] cf_release;

    // Mapper state copy
    logic [ACTIONS-1:0] pr_held;
    logic [TIMER_W-1:0] pr_countdown [ACTIONS];
    logic [ACTIONS-1:0] pr_fired;
    logic [DIRS-1:0]    pr_stick;
    logic               pr_focus;
    logic               pr_ptr_seen;
    logic [PTR_W-1:0]   pr_last_x;
    logic [PTR_W-1:0]   pr_last_y;

    int          errors = 0;
    int unsigned in_gap = 0;
    int unsigned out_stall = 0;
    int unsigned in_draw;
    int unsigned out_draw;
    bit          feed_gaps_on = 1'b1;
    bit          drain_stalls_on = 1'b1;
    int unsigned el_span = 1000;
    nav_item_t   walk = '0;

    always #5 clk = ~clk;

    nav_input_autorepeat_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cur_write.idx),
        .cfg_data        (cur_write.data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (cur_item.command),
        .elapsed_us      (cur_item.elapsed_us),
        .axis_x          (cur_item.axis_x),
        .axis_y          (cur_item.axis_y),
        .up_buttons      (cur_item.up_buttons),
        .down_buttons    (cur_item.down_buttons),
        .left_buttons    (cur_item.left_buttons),
        .right_buttons   (cur_item.right_buttons),
        .confirm_buttons (cur_item.confirm_buttons),
        .cancel_buttons  (cur_item.cancel_buttons),
        .pointer_x       (cur_item.pointer_x),
        .pointer_y       (cur_item.pointer_y),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fired_actions   (fired_actions),
        .focus_shown     (focus_shown),
        .stick_active    (stick_active)
    );

    // Mapper state back to its reset values; registers are kept
    function automatic void clear_mapper();
        pr_held = '1;
        foreach (pr_countdown[i])
            pr_countdown[i] = '0;
        pr_fired = '0;
        pr_stick = '0;
        pr_focus = 1'b0;
        pr_ptr_seen = 1'b0;
        pr_last_x = '0;
        pr_last_y = '0;
    endfunction

    // Negation that maps the most negative axis value to the most positive one
    function automatic int negate_clamped(logic signed [AXIS_W-1:0] v);
        int x;
        x = v;
        return (x < -AXIS_TOP) ? AXIS_TOP : -x;
    endfunction

    function automatic nav_result_t predict_mapper(nav_item_t it);
        nav_result_t        r;
        int                 amount [DIRS];
        int                 lvl;
        int                 i;
        int unsigned        dt;
        logic [ACTIONS-1:0] pressed;
        if (it.command == CMD_RESET)
            clear_mapper();
        else
        begin
            dt = it.elapsed_us;
            amount[ACT_UP]    = it.axis_y;
            amount[ACT_DOWN]  = negate_clamped(it.axis_y);
            amount[ACT_LEFT]  = negate_clamped(it.axis_x);
            amount[ACT_RIGHT] = it.axis_x;
            // hysteresis: an active direction holds down to the release level
            for (i = 0; i < DIRS; i++)
            begin
                lvl = pr_stick[i] ? int'(cf_release) : int'(cf_trigger);
                pr_stick[i] = (amount[i] >= lvl);
            end
            pressed[ACT_UP]      = (|it.up_buttons)    | pr_stick[ACT_UP];
            pressed[ACT_DOWN]    = (|it.down_buttons)  | pr_stick[ACT_DOWN];
            pressed[ACT_LEFT]    = (|it.left_buttons)  | pr_stick[ACT_LEFT];
            pressed[ACT_RIGHT]   = (|it.right_buttons) | pr_stick[ACT_RIGHT];
            pressed[ACT_CONFIRM] = |it.confirm_buttons;
            pressed[ACT_CANCEL]  = |it.cancel_buttons;
            // press edge, then typematic repeat for the directions only;
            // 19-bit registers always fit the countdown, so loads never saturate
            for (i = 0; i < ACTIONS; i++)
            begin
                pr_fired[i] = 1'b0;
                if (!pressed[i])
                begin
                    pr_held[i] = 1'b0;
                    pr_countdown[i] = '0;
                end
                else if (!pr_held[i])
                begin
                    pr_held[i] = 1'b1;
                    pr_fired[i] = 1'b1;
                    pr_countdown[i] = TIMER_W'(cf_delay);
                end
                else if (i < DIRS)
                begin
                    if (dt >= pr_countdown[i])
                    begin
                        pr_fired[i] = 1'b1;
                        pr_countdown[i] = TIMER_W'(cf_interval);
                    end
                    else
                        pr_countdown[i] = pr_countdown[i] - TIMER_W'(dt);
                end
            end
            // focus mark: shown on any firing, hidden by pointer movement
            if (|pr_fired)
                pr_focus = 1'b1;
            if (pr_ptr_seen && (it.pointer_x != pr_last_x || it.pointer_y != pr_last_y))
                pr_focus = 1'b0;
            pr_ptr_seen = 1'b1;
            pr_last_x = it.pointer_x;
            pr_last_y = it.pointer_y;
        end
        r.fired = pr_fired;
        r.focus = pr_focus;
        r.stick = pr_stick;
        return r;
    endfunction

    function automatic nav_item_t tick(int dt, int ax, int ay, int up, int dn, int lt, int rt,
                                       int cf, int cn, int px, int py);
        nav_item_t it;
        it.command = CMD_TICK;
        it.elapsed_us = DT_W'(dt);
        it.axis_x = AXIS_W'(ax);
        it.axis_y = AXIS_W'(ay);
        it.up_buttons = BTN_DIR_W'(up);
        it.down_buttons = BTN_DIR_W'(dn);
        it.left_buttons = BTN_DIR_W'(lt);
        it.right_buttons = BTN_DIR_W'(rt);
        it.confirm_buttons = BTN_ACT_W'(cf);
        it.cancel_buttons = BTN_ACT_W'(cn);
        it.pointer_x = PTR_W'(px);
        it.pointer_y = PTR_W'(py);
        return it;
    endfunction

    // Stick values clustered round the levels and the extremes
    function automatic logic signed [AXIS_W-1:0] pick_axis();
        int v;
        int sgn;
        sgn = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 5))
            0: v = -AXIS_TOP - 1;
            1: v = AXIS_TOP;
            2: v = 0;
            3: v = sgn * (int'(cf_trigger) + int'($urandom_range(0, 4)) - 2);
            4: v = sgn * (int'(cf_release) + int'($urandom_range(0, 4)) - 2);
            default: v = int'($urandom_range(0, 2 * AXIS_TOP + 1)) - AXIS_TOP - 1;
        endcase
        if (v > AXIS_TOP)
            v = AXIS_TOP;
        if (v < -AXIS_TOP - 1)
            v = -AXIS_TOP - 1;
        return AXIS_W'(v);
    endfunction

    function automatic int pick_buttons(int hi);
        return $urandom_range(0, 1) ? 0 : int'($urandom_range(1, hi));
    endfunction

    // Held-input walk with random content, plus some noise and resets
    function automatic nav_item_t next_random_item();
        logic [127:0] noise;
        nav_item_t    it;
        if ($urandom_range(0, 7) == 0)
        begin
            noise = {$urandom(), $urandom(), $urandom(), $urandom()};
            it = noise[$bits(nav_item_t)-1:0];
            it.command = CMD_TICK;
            return it;
        end
        if ($urandom_range(0, 49) == 0)
        begin
            it = walk;
            it.command = CMD_RESET;
            return it;
        end
        walk.command = CMD_TICK;
        case ($urandom_range(0, 9))
            0: walk.elapsed_us = '0;
            1: walk.elapsed_us = DT_W'(DT_MAX);
            2: walk.elapsed_us = DT_W'($urandom_range(0, DT_MAX));
            default: walk.elapsed_us = DT_W'($urandom_range(0, el_span));
        endcase
        if ($urandom_range(0, 5) == 0)
            walk.up_buttons = BTN_DIR_W'(pick_buttons(7));
        if ($urandom_range(0, 5) == 0)
            walk.down_buttons = BTN_DIR_W'(pick_buttons(7));
        if ($urandom_range(0, 5) == 0)
            walk.left_buttons = BTN_DIR_W'(pick_buttons(7));
        if ($urandom_range(0, 5) == 0)
            walk.right_buttons = BTN_DIR_W'(pick_buttons(7));
        if ($urandom_range(0, 5) == 0)
            walk.confirm_buttons = BTN_ACT_W'(pick_buttons(3));
        if ($urandom_range(0, 5) == 0)
            walk.cancel_buttons = BTN_ACT_W'(pick_buttons(3));
        if ($urandom_range(0, 4) == 0)
            walk.axis_x = pick_axis();
        if ($urandom_range(0, 4) == 0)
            walk.axis_y = pick_axis();
        if ($urandom_range(0, 9) == 0)
        begin
            walk.pointer_x = PTR_W'($urandom_range(0, 65535));
            walk.pointer_y = PTR_W'($urandom_range(0, 65535));
        end
        return walk;
    endfunction

    // Wait until every queued write and item has gone through and been checked
    task automatic settle();
        int n;
        n = 0;
        while ((pending_items.size() != 0 || in_valid || pending_writes.size() != 0 ||
                cfg_valid || expected_results.size() != 0) && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(int delay, int interval, int trig, int rel, int span);
        pending_writes.push_back('{CFG_FIRST_WAIT, DELAY_W'(delay)});
        pending_writes.push_back('{CFG_REPEAT_PERIOD, DELAY_W'(interval)});
        pending_writes.push_back('{CFG_TRIGGER_LEVEL, DELAY_W'(trig)});
        pending_writes.push_back('{CFG_RELEASE_LEVEL, DELAY_W'(rel)});
        settle();
        el_span = span;
    endtask

    task automatic run_random(int count, bit gaps, bit stalls);
        feed_gaps_on = gaps;
        drain_stalls_on = stalls;
        repeat (count)
            pending_items.push_back(next_random_item());
        settle();
    endtask

    // Register write driver; the copy follows each accepted write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_valid <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cur_write.idx)
                    CFG_FIRST_WAIT:      cf_delay = cur_write.data;
                    CFG_REPEAT_PERIOD:   cf_interval = cur_write.data;
                    CFG_TRIGGER_LEVEL:   cf_trigger = cur_write.data[LEVEL_W-1:0];
                    CFG_RELEASE_LEVEL:   cf_release = cur_write.data[LEVEL_W-1:0];
                    default:             ;
                endcase
            end
            if ((!cfg_valid || cfg_ready) && pending_writes.size() != 0)
            begin
                cur_write <= pending_writes.pop_front();
                cfg_valid <= 1'b1;
            end
            else if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;
        end
    end

    // Item driver: predicts on acceptance, then idles for a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else if (in_valid && in_ready)
        begin
            expected_results.push_back(predict_mapper(cur_item));
            in_draw = feed_gaps_on ? $urandom_range(0, 11) : 0;
            if (in_draw == 0 && pending_items.size() != 0)
                cur_item <= pending_items.pop_front();
            else
            begin
                in_valid <= 1'b0;
                in_gap <= in_draw;
            end
        end
        else if (!in_valid)
        begin
            if (in_gap != 0)
                in_gap <= in_gap - 1;
            else if (pending_items.size() != 0)
            begin
                cur_item <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result fired %h focus %b stick %h", $time,
                         fired_actions, focus_shown, stick_active);
            end
            else
            begin
                if (fired_actions != expected_results[0].fired)
                begin
                    errors++;
                    $display("%0t: fired_actions expected %h got %h", $time,
                             expected_results[0].fired, fired_actions);
                end
                if (focus_shown != expected_results[0].focus)
                begin
                    errors++;
                    $display("%0t: focus_shown expected %b got %b", $time,
                             expected_results[0].focus, focus_shown);
                end
                if (stick_active != expected_results[0].stick)
                begin
                    errors++;
                    $display("%0t: stick_active expected %h got %h", $time,
                             expected_results[0].stick, stick_active);
                end
                void'(expected_results.pop_front());
            end
            out_draw = drain_stalls_on ? $urandom_range(0, 11) : 0;
            if (out_draw != 0)
            begin
                out_ready <= 1'b0;
                out_stall <= out_draw;
            end
        end
        else if (!out_ready)
        begin
            if (out_stall != 0)
                out_stall <= out_stall - 1;
            else
                out_ready <= 1'b1;
        end
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        nav_item_t r;
        cf_delay = RESET_DELAY;
        cf_interval = RESET_INTERVAL;
        cf_trigger = RESET_TRIGGER;
        cf_release = RESET_RELEASE;
        clear_mapper();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset register values
        pending_items.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 100, 200));         // first pointer
        pending_items.push_back(tick(1000, 0, 0, 1, 0, 0, 0, 0, 0, 100, 200));      // arrow press
        pending_items.push_back(tick(DT_MAX, 0, 0, 2, 0, 0, 0, 0, 0, 100, 200));    // delay runs
        pending_items.push_back(tick(DT_MAX, 0, 0, 4, 0, 0, 0, 0, 0, 100, 200));    // first repeat
        pending_items.push_back(tick(0, 0, 0, 7, 0, 0, 0, 0, 0, 100, 200));
        pending_items.push_back(tick(10, 0, 0, 0, 0, 0, 0, 0, 0, 101, 200));        // pointer hides
        pending_items.push_back(tick(500, 0, -32768, 0, 0, 0, 0, 0, 0, 101, 200));  // saturating down
        pending_items.push_back(tick(500, 0, -8192, 0, 0, 0, 0, 0, 0, 101, 200));   // at release
        pending_items.push_back(tick(500, 0, -8191, 0, 0, 0, 0, 0, 0, 101, 200));   // below release
        pending_items.push_back(tick(500, 0, 16384, 0, 0, 0, 0, 0, 0, 101, 200));   // at trigger
        pending_items.push_back(tick(500, -32768, 16383, 0, 0, 0, 0, 0, 0, 101, 200));
        pending_items.push_back(tick(500, 32767, 0, 0, 0, 0, 0, 0, 0, 101, 200));
        pending_items.push_back(tick(500, 16383, 0, 0, 0, 0, 0, 0, 0, 101, 200));
        pending_items.push_back(tick(DT_MAX, 0, 0, 0, 0, 0, 0, 1, 0, 101, 201));    // fire and move
        pending_items.push_back(tick(DT_MAX, 0, 0, 0, 0, 0, 0, 2, 0, 101, 201));    // no repeat
        pending_items.push_back(tick(100, 0, 0, 0, 0, 0, 0, 3, 2, 101, 201));
        r = tick(DT_MAX, -32768, 32767, 7, 7, 7, 7, 3, 3, 65535, 65535);
        r.command = CMD_RESET;
        pending_items.push_back(r);
        pending_items.push_back(tick(DT_MAX, -32768, 32767, 7, 7, 7, 7, 3, 3, 65535, 65535));
        pending_items.push_back(tick(DT_MAX, -32768, 32767, 7, 7, 7, 7, 3, 3, 65535, 65535));
        pending_items.push_back(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 65535));
        pending_items.push_back(tick(0, 0, 0, 7, 7, 7, 7, 3, 3, 65535, 65535));     // all press
        r.command = CMD_RESET;
        pending_items.push_back(r);
        pending_items.push_back(tick(5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        settle();

        // Random phases over several register settings
        configure(3000, 1000, 12000, 6000, 700);
        run_random(185, 1'b1, 1'b1);
        configure(0, 0, 0, 0, 40);
        run_random(185, 1'b0, 1'b0);
        configure(524287, 524287, 32767, 32767, DT_MAX);
        run_random(185, 1'b1, 1'b0);
        configure($urandom_range(0, 20000), $urandom_range(1, 5000),
                  $urandom_range(0, 32767), $urandom_range(0, 32767), 2000);
        run_random(185, 1'b0, 1'b1);
        configure($urandom_range(0, 524287), $urandom_range(1, 524287),
                  $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(1, DT_MAX));
        run_random(185, 1'b1, 1'b1);

        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
